FILE: hdl/composite_number_counter_macros.svh
// Assertion macros shared by the composite number counter checkers.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef COMPOSITE_NUMBER_COUNTER_MACROS_SVH
`define COMPOSITE_NUMBER_COUNTER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CCN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CCN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ccn_pkg.sv
// Package for the composite number counter: widths, constants and payload types.
// No dependencies; imported by every module of the block.
package ccn_pkg;

  // Width of the tested number
  localparam int VALUE_WIDTH = 16;
  // Width of the input value field and of the running count field
  localparam int FIELD_W     = 16;
  localparam int COUNT_W     = 16;
  // Candidate divisor width: covers sqrt of the largest value plus one step
  localparam int D_W         = VALUE_WIDTH / 2 + 3;
  // Width of the candidate square
  localparam int SQ_W        = 2 * D_W;
  // Bit counter of the serial remainder unit
  localparam int CNT_W       = $clog2(VALUE_WIDTH);

  // Trial division constants
  localparam int FIRST_CAND  = 5;
  localparam int CAND_STEP   = 6;
  localparam int PAIR_GAP    = 2;
  localparam int SMALL_DIV   = 3;
  localparam int FIRST_SQ    = FIRST_CAND * FIRST_CAND;
  localparam int SQ_STEP     = CAND_STEP * CAND_STEP;
  localparam int SQ_LIN      = 2 * CAND_STEP;
  localparam int LARGEST_NON = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic               restart;
  } in_item_t;

  typedef struct packed {
    logic               is_composite;
    logic [COUNT_W-1:0] running_count;
  } out_item_t;

  // Request to the serial remainder unit
  typedef struct packed {
    logic           start;
    logic [D_W-1:0] divisor;
  } rem_req_t;

  // Response from the serial remainder unit
  typedef struct packed {
    logic done;
    logic zero;
  } rem_rsp_t;

endpackage

FILE: hdl/ccn_rem.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on ccn_pkg for widths and the request/response structs.
module ccn_rem import ccn_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  rem_req_t               req,
  output rem_rsp_t               rsp
);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic                   zero_r, zero_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [VALUE_WIDTH-1:0] shift_r, shift_nxt;
  logic [D_W-1:0]         rem_r, rem_nxt;
  logic [D_W-1:0]         div_r, div_nxt;

  logic [D_W:0]           trial;
  logic [D_W:0]           diff;
  logic [D_W-1:0]         rem_step;
  logic                   last;

  // One restoring step: bring in the next dividend bit, subtract if it fits
  assign trial    = {rem_r, shift_r[VALUE_WIDTH-1]};
  assign diff     = trial - {1'b0, div_r};
  assign rem_step = (trial >= {1'b0, div_r}) ? diff[D_W-1:0] : trial[D_W-1:0];
  assign last     = (cnt_r == CNT_W'(VALUE_WIDTH - 1));

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    zero_nxt  = zero_r;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    if (req.start) begin
      // load a new division
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      shift_nxt = dividend;
      rem_nxt   = '0;
      div_nxt   = req.divisor;
    end else if (busy_r) begin
      // advance one bit
      rem_nxt   = rem_step;
      shift_nxt = {shift_r[VALUE_WIDTH-2:0], 1'b0};
      cnt_nxt   = cnt_r + CNT_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        zero_nxt = (rem_step == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      zero_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      zero_r <= zero_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers hold no reset
  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.zero = zero_r;

endmodule

FILE: hdl/composite_number_counter.sv
// Top level of the composite number counter: trial division sequencer and count.
// Depends on ccn_pkg and the serial remainder unit ccn_rem.
//
//   channel | direction | payload     | handshake
//   in      | input     | in_item_t   | in_valid / in_stall
//   out     | output    | out_item_t  | out_valid / out_stall
//
// Values 0 to 3 and even values go from accept straight to the verdict; odd values
// first take the remainder by three, then the remainders by each 6k-1/6k+1 candidate
// pair from the bit-serial remainder unit, until a remainder is zero or the
// candidate squared passes the value.
// One item is in work at a time; a new one is taken while the last result waits.
// A stalled result holds; the verdict then waits until the output register frees.
// Synchronous active-low reset clears the state machine, valid and the count.
module composite_number_counter import ccn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV3,
    ST_CHK,
    ST_DIVA,
    ST_DIVB,
    ST_FIN
  } state_t;

  state_t                 state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] n_r, n_nxt;
  logic                   restart_r, restart_nxt;
  logic                   comp_r, comp_nxt;
  logic [D_W-1:0]         d_r, d_nxt;
  logic [SQ_W-1:0]        sq_r, sq_nxt;
  logic [COUNT_W-1:0]     count_r, count_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  rem_req_t               rem_req;
  rem_rsp_t               rem_rsp;
  logic [VALUE_WIDTH-1:0] in_n;
  logic                   accept;
  logic                   out_free;
  logic [COUNT_W-1:0]     count_base;

  // The dividend is loaded with the start pulse, so take the value being latched
  ccn_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .dividend (n_nxt),
    .req      (rem_req),
    .rsp      (rem_rsp)
  );

  assign in_n     = VALUE_WIDTH'(in_data.value);
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  // Restart clears the count before this transaction is counted
  assign count_base = restart_r ? '0 : count_r;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    restart_nxt   = restart_r;
    comp_nxt      = comp_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rem_req       = '{start: 1'b0, divisor: d_r};

    // Drop the result once it is taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          n_nxt       = in_n;
          restart_nxt = in_data.restart;
          if (in_n <= VALUE_WIDTH'(LARGEST_NON)) begin
            comp_nxt  = 1'b0;
            state_nxt = ST_FIN;
          end else if (!in_n[0]) begin
            comp_nxt  = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_DIV3;
          end
        end
      end
      ST_DIV3: begin
        // Wait for the remainder by three, started on the accept
        if (rem_rsp.done) begin
          if (rem_rsp.zero) begin
            comp_nxt  = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            d_nxt     = D_W'(FIRST_CAND);
            sq_nxt    = SQ_W'(FIRST_SQ);
            state_nxt = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        // Stop once the candidate squared passes the value
        if (sq_r > SQ_W'(n_r)) begin
          comp_nxt  = 1'b0;
          state_nxt = ST_FIN;
        end else begin
          rem_req   = '{start: 1'b1, divisor: d_r};
          state_nxt = ST_DIVA;
        end
      end
      ST_DIVA: begin
        if (rem_rsp.done) begin
          if (rem_rsp.zero) begin
            comp_nxt  = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            rem_req   = '{start: 1'b1, divisor: d_r + D_W'(PAIR_GAP)};
            state_nxt = ST_DIVB;
          end
        end
      end
      ST_DIVB: begin
        if (rem_rsp.done) begin
          if (rem_rsp.zero) begin
            comp_nxt  = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            // (d+6)^2 = d^2 + 12d + 36
            d_nxt     = d_r + D_W'(CAND_STEP);
            sq_nxt    = sq_r + SQ_W'(d_r) * SQ_W'(SQ_LIN) + SQ_W'(SQ_STEP);
            state_nxt = ST_CHK;
          end
        end
      end
      ST_FIN: begin
        // Hold the verdict until the output register is free
        if (out_free) begin
          if (comp_r && (count_base != COUNT_MAX)) begin
            count_nxt = count_base + COUNT_W'(1);
          end else begin
            count_nxt = count_base;
          end
          out_data_nxt.is_composite  = comp_r;
          out_data_nxt.running_count = (comp_r && (count_base != COUNT_MAX)) ?
                                       count_base + COUNT_W'(1) : count_base;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Kick off the division by three when leaving idle for it
    if ((state_r == ST_IDLE) && (state_nxt == ST_DIV3)) begin
      rem_req = '{start: 1'b1, divisor: D_W'(SMALL_DIV)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    restart_r  <= restart_nxt;
    comp_r     <= comp_nxt;
    d_r        <= d_nxt;
    sq_r       <= sq_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hdl/ccn_checker.sv
// Port-level checker for the composite number counter, bound to the top level.
// Depends on ccn_pkg and composite_number_counter_macros.svh.
`include "composite_number_counter_macros.svh"

module ccn_port_checker import ccn_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A stalled result stays offered
  `CCN_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "out_valid dropped under stall")

  // A stalled result keeps its payload
  `CCN_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_data), "out_data changed under stall")

  // A composite verdict always comes with a nonzero count
  `CCN_ASSERT_NOW(a_count_nz, out_valid && out_data.is_composite, out_data.running_count != '0, "composite with zero count")

  // Only one transaction is in work: the input stalls right after an accept
  `CCN_ASSERT_NXT(a_one_item, in_valid && !in_stall, in_stall, "input taken while busy")

endmodule

bind composite_number_counter ccn_port_checker u_ccn_checker (.*);

FILE: dv/ccn_checker.sv
// Checker for the composite number counter: watches both channels, predicts each verdict.
// Depends on ccn_pkg for the payload types and the count ceiling.
module ccn_checker import ccn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  output int unsigned mismatches,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Trial division: the even and the multiple-of-three test, then 6k-1 / 6k+1 pairs
  localparam int unsigned LARGEST_PLAIN = 3;
  localparam int unsigned FIRST_TRIAL   = 5;
  localparam int unsigned TRIAL_STEP    = 6;
  localparam int unsigned TWIN_GAP      = 2;

  out_item_t            expected_verdicts[$];
  logic [COUNT_W-1:0]   composite_total = '0;
  int unsigned          error_count = 0;

  function automatic logic has_divisor(input logic [VALUE_WIDTH-1:0] n);
    int unsigned v;
    int unsigned d;
    v = n;
    if (v <= LARGEST_PLAIN) return 1'b0;
    if (v % 2 == 0 || v % 3 == 0) return 1'b1;
    for (d = FIRST_TRIAL; d * d <= v; d += TRIAL_STEP) begin
      if (v % d == 0 || v % (d + TWIN_GAP) == 0) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the running count and build the verdict for one accepted number
  function automatic out_item_t predict_verdict(input in_item_t item);
    out_item_t verdict;
    logic      comp;
    comp = has_divisor(item.value[VALUE_WIDTH-1:0]);
    if (item.restart) composite_total = '0;
    if (comp && composite_total != COUNT_MAX) composite_total = composite_total + 1'b1;
    verdict.is_composite  = comp;
    verdict.running_count = composite_total;
    return verdict;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // Compare the outgoing transaction first, then queue the prediction for the incoming one
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      expected_verdicts.delete();
      composite_total = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("unexpected result composite=%0b count=%0d",
                                    out_data.is_composite, out_data.running_count));
        end else begin
          want = expected_verdicts.pop_front();
          if (out_data.is_composite !== want.is_composite)
            report_mismatch($sformatf("is_composite got %0b want %0b",
                                      out_data.is_composite, want.is_composite));
          if (out_data.running_count !== want.running_count)
            report_mismatch($sformatf("running_count got %0d want %0d",
                                      out_data.running_count, want.running_count));
        end
      end
      if (in_valid && !in_stall)
        expected_verdicts = {expected_verdicts, predict_verdict(in_data)};
    end
    pending    <= expected_verdicts.size();
    mismatches <= error_count;
  end

endmodule

FILE: dv/tb_composite_number_counter.sv
// Testbench top for the composite number counter: clock, reset, stimulus and verdict.
// Depends on ccn_pkg, composite_number_counter and the checker ccn_checker.
module tb_composite_number_counter import ccn_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned PHASE_ITEMS  = 130;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  composite_number_counter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  ccn_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result channel at the current rate
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Present one transaction after a random idle gap, hold it until accepted
  task automatic send_item(input logic [FIELD_W-1:0] value, input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data.value   <= value;
    in_data.restart <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Mix of full-range, odd, products of trial candidates, tiny and near-top numbers
  function automatic logic [FIELD_W-1:0] pick_value();
    int unsigned sel;
    int unsigned p;
    int unsigned q;
    sel = $urandom_range(99);
    p   = 6 * $urandom_range(42, 1) - 1 + 2 * $urandom_range(1);
    q   = 6 * $urandom_range(42, 1) - 1 + 2 * $urandom_range(1);
    if (sel < 30) return FIELD_W'($urandom_range(65535));
    else if (sel < 50) return FIELD_W'($urandom_range(65535) | 1);
    else if (sel < 65) return FIELD_W'(p * q);
    else if (sel < 80) return FIELD_W'($urandom_range(31));
    else return FIELD_W'($urandom_range(65535, 65024));
  endfunction

  task automatic send_random(input int unsigned count);
    repeat (count) send_item(pick_value(), $urandom_range(15) == 0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles now and then, receiver mostly stalls
    send_idle_pct  = 33;
    recv_stall_pct = 87;

    // Small values, first candidates, candidate squares and products, top of range
    send_item(16'd0, 1'b1);     send_item(16'd1, 1'b0);     send_item(16'd2, 1'b0);
    send_item(16'd3, 1'b0);     send_item(16'd4, 1'b0);     send_item(16'd5, 1'b0);
    send_item(16'd6, 1'b0);     send_item(16'd7, 1'b0);     send_item(16'd8, 1'b0);
    send_item(16'd9, 1'b0);     send_item(16'd24, 1'b0);    send_item(16'd25, 1'b0);
    send_item(16'd35, 1'b0);    send_item(16'd49, 1'b0);    send_item(16'd121, 1'b0);
    send_item(16'd143, 1'b0);   send_item(16'd169, 1'b0);   send_item(16'd289, 1'b0);
    send_item(16'd323, 1'b0);   send_item(16'd63001, 1'b0); send_item(16'd65521, 1'b0);
    send_item(16'd65534, 1'b0); send_item(16'd65535, 1'b0);
    // Restart on a composite, then on a prime
    send_item(16'd4, 1'b1);
    send_item(16'd7, 1'b1);

    send_random(PHASE_ITEMS);

    // Sender mostly idle, receiver stalls now and then
    send_idle_pct  = 87;
    recv_stall_pct = 33;
    send_random(PHASE_ITEMS);

    // Full rate on both sides
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_random(PHASE_ITEMS);

    // Top of range and small values back to back, then restarts on a prime and a composite
    send_item(16'd65534, 1'b0);
    send_item(16'd65535, 1'b0);
    send_item(16'd65521, 1'b0);
    send_item(16'd0, 1'b0);
    send_item(16'd9, 1'b0);
    send_item(16'd65521, 1'b1);
    send_item(16'd15, 1'b1);
    in_valid <= 1'b0;

    // Wait for every verdict, then watch for stray results
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
